### hw/rtl/tlec_pkg.sv
// ----------------------------------------------------------------------------
// tlec_pkg
// Shared types and constants of the two-level exclusive cache.
// ----------------------------------------------------------------------------
package tlec_pkg;

    localparam int unsigned CNT_COUNT = 7;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 12;

    localparam logic [1:0] LVL_L1   = 2'd0;
    localparam logic [1:0] LVL_L2   = 2'd1;
    localparam logic [1:0] LVL_MISS = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] l1_acc;
        logic [CNT_W-1:0] l2_acc;
        logic [CNT_W-1:0] l1_hit;
        logic [CNT_W-1:0] l1_miss;
        logic [CNT_W-1:0] l2_hit;
        logic [CNT_W-1:0] l2_miss;
        logic [CNT_W-1:0] mem;
    } t_counters;

    typedef struct packed {
        logic       inc_l1_hit;
        logic       inc_l1_miss;
        logic       inc_l2_hit;
        logic       inc_l2_miss;
        logic [1:0] inc_mem;
    } t_cnt_upd;

endpackage

### hw/rtl/tlec_counters.sv
// ----------------------------------------------------------------------------
// tlec_counters
// Seven wrapping statistic counters, updated once per access.
// ----------------------------------------------------------------------------
module tlec_counters (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  tlec_pkg::t_cnt_upd   i_upd,
    output tlec_pkg::t_counters  o_cnt
);
    import tlec_pkg::*;

    t_counters r_cnt;
    t_counters n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_update) begin
            n_cnt.l1_acc = r_cnt.l1_acc + 32'd1;
            if (i_upd.inc_l1_hit) begin
                n_cnt.l1_hit = r_cnt.l1_hit + 32'd1;
            end
            if (i_upd.inc_l1_miss) begin
                n_cnt.l1_miss = r_cnt.l1_miss + 32'd1;
                n_cnt.l2_acc  = r_cnt.l2_acc + 32'd1;
            end
            if (i_upd.inc_l2_hit) begin
                n_cnt.l2_hit = r_cnt.l2_hit + 32'd1;
            end
            if (i_upd.inc_l2_miss) begin
                n_cnt.l2_miss = r_cnt.l2_miss + 32'd1;
            end
            n_cnt.mem = r_cnt.mem + {30'd0, i_upd.inc_mem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;
endmodule

### hw/rtl/two_level_exclusive_cache_core.sv
// ----------------------------------------------------------------------------
// two_level_exclusive_cache_core
// Direct-mapped L1 over an exclusive LRU L2 with write-through main memory.
// ----------------------------------------------------------------------------
// An access is accepted in the idle state, where the L1 entry, the L2 set
// and main memory are read from synchronous memories; the execute state then
// decides and writes L1 when needed, every L2 way with its rank, and memory
// on a write. A new transaction is accepted when the previous result has been
// taken or is being taken. After reset a clearing pass zeroes all MEMORY_WORDS
// words of main memory, one word a cycle, while no transaction is accepted.
module two_level_exclusive_cache_core #(
    parameter int unsigned SET_COUNT    = 16,
    parameter int unsigned L2_WAY_COUNT = 8,
    parameter int unsigned MEMORY_WORDS = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: address[11:0], write_data[43:12], zero[47:44]
    input  logic [47:0]  s_axis_tdata,
    // tuser: cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_data[31:0], l1_accesses, l2_accesses, l1_hits, l1_misses,
    // l2_hits, l2_misses, memory_accesses[255:224]
    output logic [255:0] m_axis_tdata,
    // tuser: hit_level
    output logic [1:0]   m_axis_tuser
);
    import tlec_pkg::*;

    localparam int unsigned SW = $clog2(SET_COUNT);
    localparam int unsigned TW = ADDR_W - SW;
    localparam int unsigned WW = $clog2(L2_WAY_COUNT);
    localparam int unsigned RW = $clog2(L2_WAY_COUNT + 1);
    localparam int unsigned MW = $clog2(MEMORY_WORDS);
    localparam int unsigned AW = (MW > ADDR_W) ? MW : ADDR_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic [TW-1:0]     tag;
        logic [DATA_W-1:0] word;
        logic [RW-1:0]     rank;
    } t_way;

    typedef t_way [L2_WAY_COUNT-1:0] t_set;

    t_state r_state;
    logic [MW:0] r_clr;

    logic [TW+DATA_W-1:0] l1_mem [SET_COUNT];
    t_set                 l2_mem [SET_COUNT];
    logic [DATA_W-1:0]    main_mem [MEMORY_WORDS];
    logic [SET_COUNT-1:0] r_l1_v;
    logic [L2_WAY_COUNT-1:0] r_l2_v [SET_COUNT];

    logic [TW+DATA_W-1:0] r_l1_rd;
    t_set                 r_l2_rd;
    logic [DATA_W-1:0]    r_mem_rd;

    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_rdata;
    logic [1:0]        r_level;

    logic accept;
    logic [SW-1:0] set_in;
    logic [SW-1:0] s;
    logic [TW-1:0] tag;
    logic [AW-1:0] addr_ext;
    logic [AW-1:0] r_addr_ext;
    logic [MW-1:0] maddr_in;
    logic [MW-1:0] maddr;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign set_in        = s_axis_tdata[SW-1:0];
    assign addr_ext      = AW'(s_axis_tdata[ADDR_W-1:0]);
    assign maddr_in      = addr_ext[MW-1:0];
    assign s             = r_addr[SW-1:0];
    assign tag           = r_addr[ADDR_W-1:SW];
    assign r_addr_ext    = AW'(r_addr);
    assign maddr         = r_addr_ext[MW-1:0];

    // Decision logic.
    logic l1v;
    logic [TW-1:0] l1t;
    logic [DATA_W-1:0] l1d;
    logic [L2_WAY_COUNT-1:0] v;
    logic l1_hit, l2_hit;
    logic [WW-1:0] hw, r0w, fw;
    logic r0f, ff;
    logic [RW-1:0] nvalid;
    t_set n_set;
    logic [L2_WAY_COUNT-1:0] n_v;
    logic n_l1v, l1_we;
    logic [TW+DATA_W-1:0] n_l1;
    logic [DATA_W-1:0] rdata;
    logic [1:0] level;
    t_cnt_upd upd;
    logic [RW-1:0] pr;
    logic [WW-1:0] pw;
    logic do_close;

    always_comb begin
        l1v = r_l1_v[s];
        {l1t, l1d} = r_l1_rd;
        v = r_l2_v[s];
        l1_hit = l1v && (l1t == tag);
        l2_hit = 1'b0; hw = '0;
        r0f = 1'b0; r0w = '0;
        ff = 1'b0; fw = '0;
        nvalid = '0;
        for (int w = L2_WAY_COUNT - 1; w >= 0; w--) begin
            if (v[w] && r_l2_rd[w].tag == tag) begin
                l2_hit = 1'b1; hw = WW'(w);
            end
            if (r_l2_rd[w].rank == '0) begin
                r0f = 1'b1; r0w = WW'(w);
            end
            if (!v[w]) begin
                ff = 1'b1; fw = WW'(w);
            end
        end
        for (int w = 0; w < L2_WAY_COUNT; w++) begin
            nvalid = nvalid + RW'(v[w]);
        end
        if (!r0f) begin
            r0w = '0;
        end
        n_set = r_l2_rd; n_v = v;
        n_l1v = l1v; n_l1 = r_l1_rd; l1_we = 1'b0;
        rdata = '0; level = LVL_MISS;
        upd = '0;
        pw = '0; do_close = 1'b0;
        if (l1_hit) begin
            upd.inc_l1_hit = 1'b1;
            level = LVL_L1;
            rdata = (r_cmd == CMD_WRITE) ? r_wdata : l1d;
            n_l1 = {l1t, rdata}; l1_we = 1'b1;
        end else begin
            upd.inc_l1_miss = 1'b1;
            if (l2_hit) begin
                upd.inc_l2_hit = 1'b1;
                level = LVL_L2;
                rdata = (r_cmd == CMD_WRITE) ? r_wdata : r_l2_rd[hw].word;
                n_l1 = {tag, rdata}; n_l1v = 1'b1; l1_we = 1'b1;
                pw = hw; do_close = 1'b1;
                if (l1v) begin
                    n_set[hw].tag = l1t; n_set[hw].word = l1d;
                end else begin
                    n_v[hw] = 1'b0;
                end
            end else begin
                upd.inc_l2_miss = 1'b1;
                if (r_cmd == CMD_READ) begin
                    rdata = r_mem_rd;
                    upd.inc_mem = 2'd1;
                    n_l1 = {tag, rdata}; n_l1v = 1'b1; l1_we = 1'b1;
                    if (l1v) begin
                        if (nvalid >= RW'(L2_WAY_COUNT)) begin
                            pw = r0w; do_close = 1'b1;
                            n_set[r0w].tag = l1t; n_set[r0w].word = l1d;
                        end else if (ff) begin
                            n_v[fw] = 1'b1;
                            n_set[fw].tag = l1t; n_set[fw].word = l1d;
                            n_set[fw].rank = nvalid;
                        end
                    end
                end
            end
        end
        pr = r_l2_rd[pw].rank;
        if (do_close) begin
            for (int j = 0; j < L2_WAY_COUNT; j++) begin
                if (WW'(j) != pw && v[j] && r_l2_rd[j].rank > pr) begin
                    n_set[j].rank = r_l2_rd[j].rank - RW'(1);
                end
            end
            if (n_v[pw]) begin
                n_set[pw].rank = nvalid - RW'(1);
            end
        end
        if (r_cmd == CMD_WRITE) begin
            upd.inc_mem = upd.inc_mem + 2'd1;
            rdata = r_wdata;
        end
    end

    logic exec;
    assign exec = (r_state == ST_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_l1_v   <= '0;
            for (int i = 0; i < SET_COUNT; i++) begin
                r_l2_v[i] <= '0;
            end
        end else begin
            if (m_axis_tready && !exec) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MW+1)'(MEMORY_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state  <= ST_IDLE;
                    r_ovalid <= 1'b1;
                    r_l1_v[s] <= n_l1v;
                    r_l2_v[s] <= n_v;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= s_axis_tuser;
            r_addr  <= s_axis_tdata[ADDR_W-1:0];
            r_wdata <= s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
        if (exec) begin
            r_rdata <= rdata;
            r_level <= level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1_rd <= l1_mem[set_in];
        if (exec && l1_we) begin
            l1_mem[s] <= n_l1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2_rd <= l2_mem[set_in];
        if (exec) begin
            l2_mem[s] <= n_set;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_rd <= main_mem[maddr_in];
        if (r_state == ST_CLEAR) begin
            main_mem[r_clr[MW-1:0]] <= '0;
        end else if (exec && r_cmd == CMD_WRITE) begin
            main_mem[maddr] <= r_wdata;
        end
    end

    t_counters cnt;

    tlec_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (exec),
        .i_upd    (upd),
        .o_cnt    (cnt)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_level;
    assign m_axis_tdata  = {cnt.mem, cnt.l2_miss, cnt.l2_hit, cnt.l1_miss,
                            cnt.l1_hit, cnt.l2_acc, cnt.l1_acc, r_rdata};
endmodule
